### design/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants of the colour-cycle sequencer
// Request and response layouts, configuration layout, request kinds,
// configuration register indexes and colour-wheel constants.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int DEF_PALETTE_DEPTH = 16;

  localparam int COLOR_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int KIND_W     = 2;
  localparam int ENTRY_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int WAIT_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT   = 2'd2;

  localparam logic [COLOR_W-1:0] WHEEL_START = 24'hFF0000;
  localparam logic [CHAN_W-1:0]  WHEEL_STEP  = 8'd3;
  localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'hFF;
  localparam logic [CHAN_W-1:0]  CHAN_MIN    = 8'h00;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ENTRY_W-1:0] entry_index;
    logic [COLOR_W-1:0] entry_color;
  } in_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               painted;
  } out_rsp_t;

  typedef struct packed {
    logic               custom_enable;
    logic [COUNT_W-1:0] color_count;
    logic [WAIT_W-1:0]  step_wait;
    logic               restart;
  } cfg_t;

endpackage

### design/ccs_palette.sv
// ----------------------------------------------------------------------------
// ccs_palette: palette memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ccs_palette #(
  parameter  int PALETTE_DEPTH = ccs_pkg::DEF_PALETTE_DEPTH,
  localparam int IDX_W         = $clog2(PALETTE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [IDX_W-1:0]            waddr,
  input  logic [ccs_pkg::COLOR_W-1:0] wdata,
  input  logic                        re,
  input  logic [IDX_W-1:0]            raddr,
  output logic [ccs_pkg::COLOR_W-1:0] rdata
);
  import ccs_pkg::*;

  logic [COLOR_W-1:0] mem_r [PALETTE_DEPTH];
  logic [COLOR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/ccs_seq.sv
// ----------------------------------------------------------------------------
// ccs_seq: step sequencer
// Small one-hot controller: wheel phase search and ramp around one channel
// stepper, palette segment scan over the palette memory, fade step.
// ----------------------------------------------------------------------------
module ccs_seq #(
  parameter  int PALETTE_DEPTH = ccs_pkg::DEF_PALETTE_DEPTH,
  localparam int IDX_W         = $clog2(PALETTE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ccs_pkg::cfg_t     cfg,
  input  logic              req_valid,
  output logic              req_ready,
  input  ccs_pkg::in_req_t  req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output ccs_pkg::out_rsp_t rsp
);
  import ccs_pkg::*;

  localparam int CNT_W = IDX_W + 1;

  localparam logic [2:0] PH_G_UP = 3'd0;
  localparam logic [2:0] PH_R_DN = 3'd1;
  localparam logic [2:0] PH_B_UP = 3'd2;
  localparam logic [2:0] PH_G_DN = 3'd3;
  localparam logic [2:0] PH_R_UP = 3'd4;
  localparam logic [2:0] PH_B_DN = 3'd5;
  localparam logic [2:0] PH_LOOP = 3'd6;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_PAL_RD   = 6'b000010,
    S_PAL_CMP  = 6'b000100,
    S_PAL_STEP = 6'b001000,
    S_WHEEL    = 6'b010000,
    S_EMIT     = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [COLOR_W-1:0] cur_r, cur_nxt;
  logic [COLOR_W-1:0] tgt_r, tgt_nxt;
  logic [COLOR_W-1:0] shown_r, shown_nxt;
  logic [IDX_W-1:0]   seg_r, seg_nxt;
  logic [2:0]         phase_r, phase_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  logic               pend_r, pend_nxt;
  logic               paint_r, paint_nxt;
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic [2:0]         spin_r, spin_nxt;

  logic               mem_we;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [COLOR_W-1:0] mem_rdata;

  logic [CNT_W-1:0]   n_used;
  logic [IDX_W-1:0]   seg_start, seg_a, seg_b, seg_pick;
  logic [CHAN_W-1:0]  wh_ch, wh_end, wh_v;
  logic               wh_up;
  logic [COLOR_W-1:0] fade_res;
  logic               do_restart;

  function automatic logic [IDX_W-1:0] seg_next(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] inc;
    inc = {1'b0, i} + CNT_W'(1);
    return (inc < n) ? inc[IDX_W-1:0] : '0;
  endfunction

  function automatic logic [CHAN_W-1:0] wheel_get(input logic [COLOR_W-1:0] c,
                                                  input logic [2:0] p);
    logic [CHAN_W-1:0] v;
    case (p)
      PH_G_UP, PH_G_DN: v = c[15:8];
      PH_R_DN, PH_R_UP: v = c[23:16];
      default:          v = c[7:0];
    endcase
    return v;
  endfunction

  function automatic logic [COLOR_W-1:0] wheel_put(input logic [COLOR_W-1:0] c,
                                                   input logic [2:0] p,
                                                   input logic [CHAN_W-1:0] v);
    logic [COLOR_W-1:0] r;
    r = c;
    case (p)
      PH_G_UP, PH_G_DN: r[15:8]  = v;
      PH_R_DN, PH_R_UP: r[23:16] = v;
      default:          r[7:0]   = v;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] phase_next(input logic [2:0] p);
    return (p >= PH_B_DN) ? PH_G_UP : p + 3'd1;
  endfunction

  ccs_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (mem_we),
    .waddr (IDX_W'(req.entry_index)),
    .wdata (req.entry_color),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    if (cfg.color_count == '0) begin
      n_used = CNT_W'(1);
    end else if (int'(cfg.color_count) > PALETTE_DEPTH) begin
      n_used = CNT_W'(PALETTE_DEPTH);
    end else begin
      n_used = CNT_W'(cfg.color_count);
    end
  end

  assign seg_start = ({1'b0, seg_r} < n_used) ? seg_r : '0;
  assign seg_a     = seg_next(seg_r, n_used);
  assign seg_b     = seg_next(seg_a, n_used);
  assign seg_pick  = pend_r ? seg_start : seg_a;

  assign wh_ch  = wheel_get(cur_r, phase_r);
  assign wh_up  = (phase_r == PH_G_UP) || (phase_r == PH_B_UP) || (phase_r == PH_R_UP);
  assign wh_end = wh_up ? CHAN_MAX : CHAN_MIN;
  assign wh_v   = wh_up ? wh_ch + WHEEL_STEP : wh_ch - WHEEL_STEP;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (cur_r[k*CHAN_W +: CHAN_W] < tgt_r[k*CHAN_W +: CHAN_W]) begin
        fade_res[k*CHAN_W +: CHAN_W] = cur_r[k*CHAN_W +: CHAN_W] + CHAN_W'(1);
      end else if (cur_r[k*CHAN_W +: CHAN_W] > tgt_r[k*CHAN_W +: CHAN_W]) begin
        fade_res[k*CHAN_W +: CHAN_W] = cur_r[k*CHAN_W +: CHAN_W] - CHAN_W'(1);
      end else begin
        fade_res[k*CHAN_W +: CHAN_W] = cur_r[k*CHAN_W +: CHAN_W];
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    tgt_nxt    = tgt_r;
    shown_nxt  = shown_r;
    seg_nxt    = seg_r;
    phase_nxt  = phase_r;
    wait_nxt   = wait_r;
    pend_nxt   = pend_r;
    paint_nxt  = paint_r;
    scan_nxt   = scan_r;
    spin_nxt   = spin_r;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = seg_pick;
    do_restart = cfg.restart;

    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          paint_nxt = 1'b0;
          state_nxt = S_EMIT;
          case (req.kind)
            KIND_TICK: begin
              if (wait_r != '0) begin
                wait_nxt = wait_r - WAIT_W'(1);
              end else if (cfg.custom_enable) begin
                if (cur_r == tgt_r || pend_r) begin
                  pend_nxt  = 1'b0;
                  seg_nxt   = seg_pick;
                  scan_nxt  = '0;
                  mem_re    = 1'b1;
                  state_nxt = S_PAL_RD;
                end else begin
                  state_nxt = S_PAL_STEP;
                end
              end else begin
                phase_nxt = (phase_r > PH_B_DN) ? PH_G_UP : phase_r;
                spin_nxt  = '0;
                state_nxt = S_WHEEL;
              end
            end
            KIND_WRITE: begin
              mem_we = (int'(req.entry_index) < PALETTE_DEPTH);
            end
            KIND_RESTART: begin
              do_restart = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_PAL_RD: begin
        cur_nxt   = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = seg_a;
        state_nxt = S_PAL_CMP;
      end
      S_PAL_CMP: begin
        tgt_nxt = mem_rdata;
        if (cur_r != mem_rdata) begin
          state_nxt = S_PAL_STEP;
        end else if (scan_r + CNT_W'(1) < n_used) begin
          seg_nxt   = seg_a;
          cur_nxt   = mem_rdata;
          scan_nxt  = scan_r + CNT_W'(1);
          mem_re    = 1'b1;
          mem_raddr = seg_b;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_PAL_STEP: begin
        shown_nxt = cur_r;
        cur_nxt   = fade_res;
        paint_nxt = 1'b1;
        wait_nxt  = cfg.step_wait;
        state_nxt = S_EMIT;
      end
      S_WHEEL: begin
        if (wh_ch == wh_end && spin_r != PH_LOOP) begin
          phase_nxt = phase_next(phase_r);
          spin_nxt  = spin_r + 3'd1;
        end else begin
          shown_nxt = cur_r;
          cur_nxt   = wheel_put(cur_r, phase_r, wh_v);
          if (wh_v == wh_end) begin
            phase_nxt = phase_next(phase_r);
          end
          paint_nxt = 1'b1;
          wait_nxt  = cfg.step_wait;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_restart) begin
      cur_nxt   = WHEEL_START;
      tgt_nxt   = '0;
      seg_nxt   = '0;
      phase_nxt = PH_G_UP;
      wait_nxt  = '0;
      pend_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= WHEEL_START;
      tgt_r   <= '0;
      shown_r <= '0;
      seg_r   <= '0;
      phase_r <= PH_G_UP;
      wait_r  <= '0;
      pend_r  <= 1'b1;
      paint_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      tgt_r   <= tgt_nxt;
      shown_r <= shown_nxt;
      seg_r   <= seg_nxt;
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      pend_r  <= pend_nxt;
      paint_r <= paint_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    spin_r <= spin_nxt;
  end

  assign rsp.color   = shown_r;
  assign rsp.painted = paint_r;

endmodule

### design/color_cycle_sequencer.sv
// Flow: a non-tick request or a waiting tick goes from idle straight to the emit state.
// A wheel tick first passes the wheel state, whose phase search skips finished ramps.
// A palette fade tick passes the step state; a tick that loads a segment first reads the
// palette, compares segments (one read each) and skips the step if all in use are flat.
// Throughput: one request at a time; the next is taken while a response waits.
// Reset: synchronous, active low; wheel mode, start colour FF0000, no response held.
// ----------------------------------------------------------------------------
// color_cycle_sequencer: timed RGB colour-cycle sequencer
// Configuration registers, response register and the step sequencer.
// ----------------------------------------------------------------------------
module color_cycle_sequencer #(
  parameter int PALETTE_DEPTH = ccs_pkg::DEF_PALETTE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ccs_pkg::in_req_t               in_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ccs_pkg::out_rsp_t              out_rsp,
  input  logic                           cfg_we,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ccs_pkg::*;

  logic               en_r, en_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_rsp_t           out_rsp_r;
  cfg_t               cfg;
  logic               cfg_restart;
  logic               rsp_valid;
  logic               rsp_ready;
  out_rsp_t           rsp;

  always_comb begin
    en_nxt      = en_r;
    count_nxt   = count_r;
    wait_nxt    = wait_r;
    cfg_restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: begin
          en_nxt      = cfg_wdata[0];
          cfg_restart = 1'b1;
        end
        CFG_COUNT: begin
          count_nxt = cfg_wdata[COUNT_W-1:0];
        end
        CFG_WAIT: begin
          wait_nxt = cfg_wdata[WAIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{custom_enable: en_r, color_count: count_r, step_wait: wait_r,
                 restart: cfg_restart};

  ccs_seq #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (in_req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  assign rsp_ready = !out_valid_r || out_ready;

  always_comb begin
    if (rsp_valid && rsp_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      count_r     <= COUNT_W'(1);
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      en_r        <= en_nxt;
      count_r     <= count_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

### design/ccs_checker.sv
// ----------------------------------------------------------------------------
// ccs_checker: port-level checks of the colour-cycle sequencer
// Watches the request and response channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module ccs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ccs_pkg::out_rsp_t out_rsp
);
  import ccs_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("response changed or dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is in work");

  a_rsp_not_early: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("response raised one cycle after its request");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid after reset");

endmodule

bind color_cycle_sequencer ccs_checker u_ccs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);

### tb/sv/color_cycle_sequencer_test.sv
// ----------------------------------------------------------------------------
// color_cycle_sequencer_test: self-checking bench for the colour-cycle sequencer
// Drives ticks, palette writes, restarts and the unused request kind through the
// valid/ready request channel while varying the mode, palette size and step
// wait between phases. A local copy of the sequencer state predicts each
// response but those of the typed directed rows, which carry their own; all are
// compared field by field in arrival order. Both channels idle at random.
// ----------------------------------------------------------------------------
module color_cycle_sequencer_test;
  import ccs_pkg::*;

  localparam int PALETTE_DEPTH = DEF_PALETTE_DEPTH;
  localparam int WHEEL_PHASES  = 6;
  localparam int ITEM_TARGET   = 1900;
  localparam int SETTLE_CYCLES = 25;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int DIRECTED_ROWS = 22;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    in_req_t  req;
    logic     typed;
    out_rsp_t rsp;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_req_t               in_req    = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_rsp_t              out_rsp;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // sequencer copy
  logic [COLOR_W-1:0] pal_q [PALETTE_DEPTH];
  logic [COLOR_W-1:0] cur_col;
  logic [COLOR_W-1:0] tgt_col;
  logic [COLOR_W-1:0] shown_col;
  logic [ENTRY_W-1:0] seg_idx;
  logic [2:0]         wheel_ph;
  logic [WAIT_W-1:0]  wait_left;
  logic               seg_load;
  logic               mode_palette;
  logic [COUNT_W-1:0] count_reg;
  logic [WAIT_W-1:0]  wait_reg;

  out_rsp_t queued_shades [$];
  out_rsp_t head_shade;
  bit       steady       = 1'b0;
  int       n_sent       = 0;
  int       n_fail       = 0;
  int       n_painted    = 0;
  int       n_phases     = 0;
  int       stall_cycles = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{KIND_UNUSED,  4'hF, 24'hFFFFFF}, 1'b1, '{24'h000000, 1'b0}},
    '{'{KIND_RESTART, 4'h0, 24'h000000}, 1'b1, '{24'h000000, 1'b0}},
    '{'{KIND_TICK,    4'h0, 24'h000000}, 1'b1, '{24'hFF0000, 1'b1}},
    '{'{KIND_TICK,    4'hF, 24'hFFFFFF}, 1'b1, '{24'hFF0300, 1'b1}},
    '{'{KIND_WRITE,   4'h0, 24'h000000}, 1'b1, '{24'hFF0300, 1'b0}},
    '{'{KIND_WRITE,   4'hF, 24'hFFFFFF}, 1'b1, '{24'hFF0300, 1'b0}},
    '{'{KIND_WRITE,   4'h1, 24'h000000}, 1'b0, '0},
    '{'{KIND_WRITE,   4'h2, 24'h020103}, 1'b0, '0},
    '{'{KIND_WRITE,   4'h3, 24'h000000}, 1'b0, '0},
    '{'{KIND_WRITE,   4'h4, 24'h800000}, 1'b0, '0},
    '{'{KIND_WRITE,   4'h5, 24'h800101}, 1'b0, '0},
    '{'{KIND_WRITE,   4'h6, 24'h7F0202}, 1'b0, '0},
    '{'{KIND_WRITE,   4'h7, 24'h7F0202}, 1'b0, '0},
    '{'{KIND_WRITE,   4'h8, 24'h55AA55}, 1'b0, '0},
    '{'{KIND_WRITE,   4'h9, 24'h56A956}, 1'b0, '0},
    '{'{KIND_WRITE,   4'hA, 24'hFEFFFE}, 1'b0, '0},
    '{'{KIND_WRITE,   4'hB, 24'h010001}, 1'b0, '0},
    '{'{KIND_WRITE,   4'hC, 24'h000102}, 1'b0, '0},
    '{'{KIND_WRITE,   4'hD, 24'hFFFFFD}, 1'b0, '0},
    '{'{KIND_WRITE,   4'hE, 24'hFFFFFF}, 1'b0, '0},
    '{'{KIND_RESTART, 4'h7, 24'h123456}, 1'b1, '{24'hFF0300, 1'b0}},
    '{'{KIND_TICK,    4'h0, 24'h000000}, 1'b1, '{24'hFF0000, 1'b1}}
  };

  color_cycle_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_sequence();
    cur_col   = WHEEL_START;
    tgt_col   = '0;
    seg_idx   = '0;
    wheel_ph  = '0;
    wait_left = '0;
    seg_load  = 1'b1;
  endfunction

  function automatic int entries_in_use();
    if (count_reg == 0) return 1;
    if (count_reg > PALETTE_DEPTH) return PALETTE_DEPTH;
    return int'(count_reg);
  endfunction

  function automatic int following(int i, int n);
    return (i + 1 < n) ? i + 1 : 0;
  endfunction

  function automatic int ramp_shift(int p);
    case (p % 3)
      0: return 8;
      1: return 16;
      default: return 0;
    endcase
  endfunction

  function automatic logic wheel_advance(output logic [COLOR_W-1:0] shade);
    int              p;
    int              sh;
    logic            up;
    logic [CHAN_W-1:0] lvl;
    p = (wheel_ph >= WHEEL_PHASES) ? 0 : int'(wheel_ph);
    // pass over ramps whose channel already sits at its end
    for (int k = 0; k < WHEEL_PHASES; k++) begin
      sh = ramp_shift(p);
      if (cur_col[sh +: CHAN_W] != ((p % 2 == 0) ? CHAN_MAX : CHAN_MIN)) break;
      p = (p == WHEEL_PHASES - 1) ? 0 : p + 1;
    end
    shade = cur_col;
    sh  = ramp_shift(p);
    up  = (p % 2 == 0);
    lvl = up ? cur_col[sh +: CHAN_W] + WHEEL_STEP : cur_col[sh +: CHAN_W] - WHEEL_STEP;
    cur_col[sh +: CHAN_W] = lvl;
    if (lvl == (up ? CHAN_MAX : CHAN_MIN)) p = (p == WHEEL_PHASES - 1) ? 0 : p + 1;
    wheel_ph = p[2:0];
    return 1'b1;
  endfunction

  function automatic logic fade_advance(output logic [COLOR_W-1:0] shade);
    int n;
    int idx;
    n     = entries_in_use();
    shade = '0;
    if (cur_col == tgt_col || seg_load) begin
      idx      = seg_load ? ((seg_idx < n) ? int'(seg_idx) : 0) : following(seg_idx, n);
      seg_load = 1'b0;
      // skip flat segments
      for (int k = 0; k < n; k++) begin
        seg_idx = idx[ENTRY_W-1:0];
        cur_col = pal_q[idx];
        tgt_col = pal_q[following(idx, n)];
        if (cur_col != tgt_col) break;
        idx = following(idx, n);
      end
      if (cur_col == tgt_col) return 1'b0;
    end
    shade = cur_col;
    for (int ch = 0; ch < COLOR_W; ch += CHAN_W) begin
      if (cur_col[ch +: CHAN_W] < tgt_col[ch +: CHAN_W]) cur_col[ch +: CHAN_W] += 1'b1;
      else if (cur_col[ch +: CHAN_W] > tgt_col[ch +: CHAN_W]) cur_col[ch +: CHAN_W] -= 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic out_rsp_t step_sequencer(in_req_t req);
    out_rsp_t           rsp;
    logic [COLOR_W-1:0] shade;
    logic               fresh;
    fresh = 1'b0;
    shade = '0;
    case (req.kind)
      KIND_TICK: begin
        if (wait_left != 0) begin
          wait_left--;
        end else begin
          fresh = mode_palette ? fade_advance(shade) : wheel_advance(shade);
          if (fresh) begin
            shown_col = shade;
            wait_left = wait_reg;
          end
        end
      end
      KIND_WRITE:   pal_q[req.entry_index] = req.entry_color;
      KIND_RESTART: restart_sequence();
      default: ;
    endcase
    rsp.color   = shown_col;
    rsp.painted = fresh;
    return rsp;
  endfunction

  function automatic logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] base);
    logic [COLOR_W-1:0] c;
    int                 lvl;
    c = base;
    for (int ch = 0; ch < COLOR_W; ch += CHAN_W) begin
      lvl = int'(base[ch +: CHAN_W]) + int'($urandom_range(4)) - 2;
      c[ch +: CHAN_W] = (lvl < 0) ? CHAN_MIN : (lvl > 255) ? CHAN_MAX : lvl[CHAN_W-1:0];
    end
    return c;
  endfunction

  function automatic in_req_t random_request(int restart_pct, int write_pct);
    in_req_t req;
    int      roll;
    req.kind        = KIND_TICK;
    req.entry_index = ENTRY_W'($urandom_range(PALETTE_DEPTH - 1));
    req.entry_color = COLOR_W'($urandom);
    roll = $urandom_range(99);
    if (roll < restart_pct) begin
      req.kind = KIND_RESTART;
    end else if (roll < restart_pct + 3) begin
      req.kind = KIND_UNUSED;
    end else if (roll < restart_pct + 3 + write_pct) begin
      req.kind = KIND_WRITE;
      if ($urandom_range(3) != 0) req.entry_color = nudge(pal_q[$urandom_range(PALETTE_DEPTH - 1)]);
    end
    return req;
  endfunction

  task automatic send_request(in_req_t req, logic typed, out_rsp_t typed_rsp);
    out_rsp_t want;
    while (!steady && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = step_sequencer(req);
    queued_shades.push_back(typed ? typed_rsp : want);
    n_sent++;
  endtask

  task automatic hold_until_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (queued_shades.size() != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_ENABLE: begin
        mode_palette = data[0];
        restart_sequence();
      end
      CFG_COUNT: count_reg = data[COUNT_W-1:0];
      CFG_WAIT:  wait_reg = data;
      default: ;
    endcase
  endtask

  task automatic load_palette();
    logic [COLOR_W-1:0] shade;
    in_req_t            req;
    shade = COLOR_W'($urandom);
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      // mostly short fades, some flat neighbours, now and then a long one
      if ($urandom_range(19) == 0) shade = COLOR_W'($urandom);
      else if ($urandom_range(3) != 0) shade = nudge(shade);
      req.kind        = KIND_WRITE;
      req.entry_index = i[ENTRY_W-1:0];
      req.entry_color = shade;
      send_request(req, 1'b0, '0);
    end
  endtask

  task automatic run_phase(logic [2:0] sel, logic en, logic [COUNT_W-1:0] cnt,
                           logic [WAIT_W-1:0] wt, int n_items, int restart_pct,
                           int write_pct, logic reload);
    hold_until_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sel[CFG_ENABLE]) cfg_write(CFG_ENABLE, CFG_DATA_W'(en));
    if (sel[CFG_COUNT]) cfg_write(CFG_COUNT, CFG_DATA_W'(cnt));
    if (sel[CFG_WAIT]) cfg_write(CFG_WAIT, wt);
    cfg_we <= 1'b0;
    if (reload) load_palette();
    for (int i = 0; i < n_items; i++) begin
      // halfway through, hold the sender until every response is back
      if (i == n_items / 2) hold_until_empty();
      send_request(random_request(restart_pct, write_pct), 1'b0, '0);
    end
    n_phases++;
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (queued_shades.size() == 0) begin
        $error("response with no request outstanding: color %06h painted %0b",
               out_rsp.color, out_rsp.painted);
        n_fail++;
      end else begin
        head_shade = queued_shades.pop_front();
        if (out_rsp.color !== head_shade.color) begin
          $error("color: expected %06h, got %06h", head_shade.color, out_rsp.color);
          n_fail++;
        end
        if (out_rsp.painted !== head_shade.painted) begin
          $error("painted: expected %0b, got %0b", head_shade.painted, out_rsp.painted);
          n_fail++;
        end
        if (out_rsp.painted === 1'b1) n_painted++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d responses outstanding",
               stall_cycles, queued_shades.size());
      $display("color_cycle_sequencer_test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic               en;
    logic [COUNT_W-1:0] cnt;
    logic [WAIT_W-1:0]  wt;
    int                 roll;
    for (int i = 0; i < PALETTE_DEPTH; i++) pal_q[i] = '0;
    mode_palette = 1'b0;
    count_reg    = COUNT_W'(1);
    wait_reg     = '0;
    shown_col    = '0;
    restart_sequence();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

    // fade over the hand-written palette
    run_phase(3'b111, 1'b1, COUNT_W'(4), '0, 60, 3, 8, 1'b0);
    // full wheel turn and wrap, no idling on either side
    steady = 1'b1;
    run_phase(3'b101, 1'b0, '0, '0, 640, 0, 2, 1'b0);
    steady = 1'b0;
    // one entry: every segment flat
    run_phase(3'b011, 1'b1, COUNT_W'(1), '0, 40, 3, 8, 1'b0);
    // zero count, then saturating count with a palette reload
    run_phase(3'b010, 1'b0, COUNT_W'(0), '0, 30, 3, 8, 1'b0);
    run_phase(3'b110, 1'b0, COUNT_W'(31), WAIT_W'(1), 150, 3, 8, 1'b1);
    // shrink the count mid-fade
    run_phase(3'b010, 1'b0, COUNT_W'(3), '0, 80, 6, 8, 1'b0);
    // longest wait, cleared by restarts
    run_phase(3'b101, 1'b0, '0, '1, 40, 15, 8, 1'b0);

    while (n_sent < ITEM_TARGET) begin
      en   = 1'($urandom_range(1));
      cnt  = ($urandom_range(1) != 0) ? COUNT_W'($urandom_range(6, 2))
                                      : COUNT_W'($urandom_range(31));
      roll = $urandom_range(9);
      wt   = (roll < 7) ? WAIT_W'($urandom_range(2)) :
             (roll < 9) ? WAIT_W'($urandom_range(20, 3)) : WAIT_W'($urandom);
      run_phase(3'($urandom_range(7)), en, cnt, wt, $urandom_range(120, 40),
                $urandom_range(6, 2), 8, en && ($urandom_range(1) != 0));
    end

    hold_until_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests over %0d register settings after the directed rows,",
             n_sent, n_phases);
    $display("with %0d painted steps among the responses checked", n_painted);
    if (n_fail == 0) begin
      $display("color_cycle_sequencer_test passed");
    end else begin
      $display("color_cycle_sequencer_test failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/ccs_pkg.sv
design/ccs_palette.sv
design/ccs_seq.sv
design/color_cycle_sequencer.sv
design/ccs_checker.sv
tb/sv/color_cycle_sequencer_test.sv
